### rtl/core/fsk4_pkg.sv
// Shared types, constants and fixed-point helpers of the 4-FSK symbol timing slicer.
// Used by fsk4_mul and fsk4_symbol_timing_slicer; depends on nothing else.
`timescale 1ns / 1ps

package fsk4_pkg;

    localparam int VALUE_WIDTH    = 16;
    localparam int COUNT_WIDTH    = 7;
    localparam int ALPHA_WIDTH    = 16;
    localparam int ACC_WIDTH      = 32;
    localparam int OP_A_WIDTH     = 34;
    localparam int OP_B_WIDTH     = 18;
    localparam int PROD_WIDTH     = OP_A_WIDTH + OP_B_WIDTH;
    localparam int CFG_DATA_WIDTH = 16;
    localparam int FILL_WIDTH     = 2;
    localparam int ROUND_SHIFT    = 16;
    localparam int RECIP3_SHIFT   = 17;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic signed [VALUE_WIDTH:0]   value_ext_t;
    typedef logic signed [ACC_WIDTH-1:0]   acc_t;
    typedef logic signed [OP_A_WIDTH-1:0]  op_a_t;
    typedef logic signed [OP_B_WIDTH-1:0]  op_b_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [PROD_WIDTH:0]    wide_t;
    typedef logic [COUNT_WIDTH-1:0]        count_t;
    typedef logic [ALPHA_WIDTH-1:0]        alpha_t;
    typedef logic [FILL_WIDTH-1:0]         fill_t;
    typedef logic [1:0]                    dibit_t;

    // Operand pair handed to the shared multiplier.
    typedef struct packed {
        op_a_t a;
        op_b_t b;
    } mul_req_t;

    typedef enum logic [0:0] {
        CFG_SYMBOL_PERIOD = 1'b0,
        CFG_SLICER_ALPHA  = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SLICE,
        ST_AVG_MUL,
        ST_AVG_ADD,
        ST_THRESH,
        ST_EYE,
        ST_ERR_MUL,
        ST_ERR_SUB,
        ST_ERR_SCALE,
        ST_ERR_ADD,
        ST_PH_MUL,
        ST_PH_ADD,
        ST_PH_WRAP,
        ST_OUT
    } state_t;

    localparam count_t PERIOD_RESET = 7'd10;
    localparam alpha_t ALPHA_RESET  = 16'd655;

    localparam value_t AVG_RESET_0 = -16'sd4096;
    localparam value_t AVG_RESET_1 = -16'sd1352;
    localparam value_t AVG_RESET_2 = 16'sd1352;
    localparam value_t AVG_RESET_3 = 16'sd4096;
    localparam value_t THR_RESET_0 = -16'sd2048;
    localparam value_t THR_RESET_1 = 16'sd0;
    localparam value_t THR_RESET_2 = 16'sd2048;

    localparam fill_t  HIST_FULL  = 2'd3;
    localparam op_b_t  ERR_GAIN   = 18'sd6554;   // 0.1 in Q0.16
    localparam op_b_t  PHASE_GAIN = 18'sd655;    // 0.01 in Q0.16
    localparam op_b_t  RECIP3     = 18'sd43691;  // ceil(2^17 / 3)
    localparam acc_t   PHASE_ONE  = 32'sd16777216;
    localparam prod_t  ROUND_HALF = prod_t'(32768);

    localparam value_t VALUE_MAX = 16'sh7FFF;
    localparam value_t VALUE_MIN = -16'sh8000;
    localparam acc_t   ACC_MAX   = 32'sh7FFFFFFF;
    localparam acc_t   ACC_MIN   = -32'sh80000000;

    // Round a Q.16 product to nearest, ties toward plus infinity.
    function automatic prod_t round_q16(prod_t p);
        return (p + ROUND_HALF) >>> ROUND_SHIFT;
    endfunction

    function automatic value_t sat_add16(value_t base, prod_t p);
        wide_t s;
        s = wide_t'(base) + wide_t'(round_q16(p));
        if (s > wide_t'(VALUE_MAX)) begin
            return VALUE_MAX;
        end else if (s < wide_t'(VALUE_MIN)) begin
            return VALUE_MIN;
        end
        return value_t'(s);
    endfunction

    function automatic acc_t sat_add32(acc_t base, prod_t p);
        wide_t s;
        s = wide_t'(base) + wide_t'(round_q16(p));
        if (s > wide_t'(ACC_MAX)) begin
            return ACC_MAX;
        end else if (s < wide_t'(ACC_MIN)) begin
            return ACC_MIN;
        end
        return acc_t'(s);
    endfunction

    // Midpoint of two levels, rounded toward minus infinity.
    function automatic value_t midpoint(value_t a, value_t b);
        value_ext_t s;
        s = value_ext_t'(a) + value_ext_t'(b);
        return value_t'(s >>> 1);
    endfunction

endpackage

### rtl/core/fsk4_symbol_timing_slicer.sv
// 4-FSK symbol timing recovery and adaptive four-level slicer, top level.
// A sample that is not a symbol decision is taken straight from idle; a decision goes through a
// 14-state sequencer around one shared multiplier, with the timing loop steps only once the
// history is full, and no new sample is accepted until its result enters the output register.
// Reset is synchronous on aresetn low and restores all averages, thresholds, history fill, loop error and phase.
// Depends on fsk4_pkg and fsk4_mul.
`timescale 1ns / 1ps

module fsk4_symbol_timing_slicer (
    input  logic                                     aclk,
    input  logic                                     aresetn,

    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic signed [fsk4_pkg::VALUE_WIDTH-1:0]  s_sample,

    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic        [1:0]                        m_dibit,
    output logic signed [fsk4_pkg::VALUE_WIDTH-1:0]  m_eye_opening,

    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic        [0:0]                        cfg_index,
    input  logic        [fsk4_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);

    // Sequencer state and configuration.
    fsk4_pkg::state_t   state_reg, state_next;
    fsk4_pkg::count_t   count_reg, count_next;
    fsk4_pkg::count_t   period_reg;
    fsk4_pkg::alpha_t   alpha_reg;

    // Adaptive slicer state: four level averages and the three decision thresholds.
    fsk4_pkg::value_t   avg_reg [4];
    fsk4_pkg::value_t   avg_next [4];
    fsk4_pkg::value_t   thr_reg [3];
    fsk4_pkg::value_t   thr_next [3];

    // Timing loop state. The history holds the last three decision samples, oldest first.
    fsk4_pkg::value_t   hist_reg [3];
    fsk4_pkg::value_t   hist_next [3];
    fsk4_pkg::fill_t    fill_reg, fill_next;
    fsk4_pkg::acc_t     err_reg, err_next;
    fsk4_pkg::acc_t     phase_reg, phase_next;

    // Per-decision working registers.
    fsk4_pkg::value_t   v_reg, v_next;
    fsk4_pkg::dibit_t   d_reg, d_next;
    logic               eye_neg_reg, eye_neg_next;
    fsk4_pkg::value_t   eye_reg, eye_next;
    fsk4_pkg::op_a_t    x_reg, x_next;

    // Output register; it lets the sequencer start on the next sample while a result waits.
    logic               m_valid_reg, m_valid_next;
    fsk4_pkg::dibit_t   m_dibit_reg, m_dibit_next;
    fsk4_pkg::value_t   m_eye_reg, m_eye_next;

    fsk4_pkg::mul_req_t mul_req;
    fsk4_pkg::prod_t    product;

    fsk4_pkg::count_t   count_inc;
    fsk4_pkg::value_ext_t eye_diff;
    fsk4_pkg::value_ext_t eye_mag;
    fsk4_pkg::value_t   eye_quot;

    fsk4_mul u_mul (
        .aclk    (aclk),
        .req     (mul_req),
        .product (product)
    );

    assign s_ready       = (state_reg == fsk4_pkg::ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_valid       = m_valid_reg;
    assign m_dibit       = m_dibit_reg;
    assign m_eye_opening = m_eye_reg;

    // The sequencer walks one decision through the shared multiplier:
    // level average update, thresholds, eye opening (a multiply by the reciprocal of three)
    // and, once the history is full, the timing error (h2 - h0) * h1, its smoothing and the phase step.
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        avg_next     = avg_reg;
        thr_next     = thr_reg;
        hist_next    = hist_reg;
        fill_next    = fill_reg;
        err_next     = err_reg;
        phase_next   = phase_reg;
        v_next       = v_reg;
        d_next       = d_reg;
        eye_neg_next = eye_neg_reg;
        eye_next     = eye_reg;
        x_next       = x_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_dibit_next = m_dibit_reg;
        m_eye_next   = m_eye_reg;
        mul_req      = '0;

        count_inc = count_reg + fsk4_pkg::COUNT_WIDTH'(1);
        eye_diff  = fsk4_pkg::value_ext_t'(avg_reg[3]) - fsk4_pkg::value_ext_t'(avg_reg[0]);
        eye_mag   = eye_diff[fsk4_pkg::VALUE_WIDTH] ? -eye_diff : eye_diff;
        eye_quot  = $signed(product[fsk4_pkg::RECIP3_SHIFT +: fsk4_pkg::VALUE_WIDTH]);

        case (state_reg)
            fsk4_pkg::ST_IDLE: begin
                // The counter wraps at its width; a period of zero makes every
                // sample a decision.
                if (s_valid) begin
                    if (count_inc < period_reg) begin
                        count_next = count_inc;
                    end else begin
                        count_next = '0;
                        v_next     = s_sample;
                        state_next = fsk4_pkg::ST_SLICE;
                    end
                end
            end

            fsk4_pkg::ST_SLICE: begin
                if (v_reg < thr_reg[0]) begin
                    d_next = 2'd0;
                end else if (v_reg < thr_reg[1]) begin
                    d_next = 2'd1;
                end else if (v_reg < thr_reg[2]) begin
                    d_next = 2'd2;
                end else begin
                    d_next = 2'd3;
                end
                state_next = fsk4_pkg::ST_AVG_MUL;
            end

            fsk4_pkg::ST_AVG_MUL: begin
                mul_req.a  = fsk4_pkg::op_a_t'(v_reg) - fsk4_pkg::op_a_t'(avg_reg[d_reg]);
                mul_req.b  = fsk4_pkg::op_b_t'(alpha_reg);
                state_next = fsk4_pkg::ST_AVG_ADD;
            end

            fsk4_pkg::ST_AVG_ADD: begin
                avg_next[d_reg] = fsk4_pkg::sat_add16(avg_reg[d_reg], product);
                state_next      = fsk4_pkg::ST_THRESH;
            end

            fsk4_pkg::ST_THRESH: begin
                thr_next[0] = fsk4_pkg::midpoint(avg_reg[0], avg_reg[1]);
                thr_next[1] = fsk4_pkg::midpoint(avg_reg[1], avg_reg[2]);
                thr_next[2] = fsk4_pkg::midpoint(avg_reg[2], avg_reg[3]);
                // Divide the magnitude by three and restore the sign afterwards,
                // which truncates toward zero.
                eye_neg_next = eye_diff[fsk4_pkg::VALUE_WIDTH];
                mul_req.a    = fsk4_pkg::op_a_t'(eye_mag);
                mul_req.b    = fsk4_pkg::RECIP3;
                hist_next[0] = hist_reg[1];
                hist_next[1] = hist_reg[2];
                hist_next[2] = v_reg;
                if (fill_reg != fsk4_pkg::HIST_FULL) begin
                    fill_next = fill_reg + fsk4_pkg::FILL_WIDTH'(1);
                end
                state_next = fsk4_pkg::ST_EYE;
            end

            fsk4_pkg::ST_EYE: begin
                eye_next = eye_neg_reg ? -eye_quot : eye_quot;
                if (fill_reg == fsk4_pkg::HIST_FULL) begin
                    state_next = fsk4_pkg::ST_ERR_MUL;
                end else begin
                    state_next = fsk4_pkg::ST_OUT;
                end
            end

            fsk4_pkg::ST_ERR_MUL: begin
                mul_req.a  = fsk4_pkg::op_a_t'(hist_reg[2]) - fsk4_pkg::op_a_t'(hist_reg[0]);
                mul_req.b  = fsk4_pkg::op_b_t'(hist_reg[1]);
                state_next = fsk4_pkg::ST_ERR_SUB;
            end

            fsk4_pkg::ST_ERR_SUB: begin
                x_next     = fsk4_pkg::op_a_t'(product) - fsk4_pkg::op_a_t'(err_reg);
                state_next = fsk4_pkg::ST_ERR_SCALE;
            end

            fsk4_pkg::ST_ERR_SCALE: begin
                mul_req.a  = x_reg;
                mul_req.b  = fsk4_pkg::ERR_GAIN;
                state_next = fsk4_pkg::ST_ERR_ADD;
            end

            fsk4_pkg::ST_ERR_ADD: begin
                err_next   = fsk4_pkg::sat_add32(err_reg, product);
                state_next = fsk4_pkg::ST_PH_MUL;
            end

            fsk4_pkg::ST_PH_MUL: begin
                mul_req.a  = fsk4_pkg::op_a_t'(err_reg);
                mul_req.b  = fsk4_pkg::PHASE_GAIN;
                state_next = fsk4_pkg::ST_PH_ADD;
            end

            fsk4_pkg::ST_PH_ADD: begin
                phase_next = fsk4_pkg::sat_add32(phase_reg, product);
                state_next = fsk4_pkg::ST_PH_WRAP;
            end

            fsk4_pkg::ST_PH_WRAP: begin
                // Passing +1.0 pulls the next decision one sample earlier. Passing -1.0
                // only wraps the phase, since the counter already sits at zero.
                if (phase_reg > fsk4_pkg::PHASE_ONE) begin
                    phase_next = phase_reg - fsk4_pkg::PHASE_ONE;
                    count_next = count_inc;
                end else if (phase_reg < -fsk4_pkg::PHASE_ONE) begin
                    phase_next = phase_reg + fsk4_pkg::PHASE_ONE;
                end
                state_next = fsk4_pkg::ST_OUT;
            end

            fsk4_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_dibit_next = d_reg;
                    m_eye_next   = eye_reg;
                    state_next   = fsk4_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = fsk4_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fsk4_pkg::ST_IDLE;
            count_reg   <= '0;
            period_reg  <= fsk4_pkg::PERIOD_RESET;
            alpha_reg   <= fsk4_pkg::ALPHA_RESET;
            avg_reg[0]  <= fsk4_pkg::AVG_RESET_0;
            avg_reg[1]  <= fsk4_pkg::AVG_RESET_1;
            avg_reg[2]  <= fsk4_pkg::AVG_RESET_2;
            avg_reg[3]  <= fsk4_pkg::AVG_RESET_3;
            thr_reg[0]  <= fsk4_pkg::THR_RESET_0;
            thr_reg[1]  <= fsk4_pkg::THR_RESET_1;
            thr_reg[2]  <= fsk4_pkg::THR_RESET_2;
            fill_reg    <= '0;
            err_reg     <= '0;
            phase_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            avg_reg     <= avg_next;
            thr_reg     <= thr_next;
            fill_reg    <= fill_next;
            err_reg     <= err_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
            // Configuration transactions must arrive only while the block is idle; it does not enforce this.
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    fsk4_pkg::CFG_SYMBOL_PERIOD: begin
                        period_reg <= cfg_data[fsk4_pkg::COUNT_WIDTH-1:0];
                    end
                    fsk4_pkg::CFG_SLICER_ALPHA: begin
                        alpha_reg <= cfg_data[fsk4_pkg::ALPHA_WIDTH-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Working and payload registers carry no reset.
    always_ff @(posedge aclk) begin
        hist_reg    <= hist_next;
        v_reg       <= v_next;
        d_reg       <= d_next;
        eye_neg_reg <= eye_neg_next;
        eye_reg     <= eye_next;
        x_reg       <= x_next;
        m_dibit_reg <= m_dibit_next;
        m_eye_reg   <= m_eye_next;
    end

    // A decision always starts from a cleared sample counter.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fsk4_pkg::ST_SLICE) |-> (count_reg == '0))
        else $error("sample counter not cleared at a symbol decision");

    // The timing loop runs only with a full symbol history.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fsk4_pkg::ST_ERR_MUL) |-> (fill_reg == fsk4_pkg::HIST_FULL))
        else $error("timing error computed from a short history");

    // Once full, the history stays full until reset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg == fsk4_pkg::HIST_FULL) |=> (fill_reg == fsk4_pkg::HIST_FULL))
        else $error("history fill count dropped");

    // A result is presented only when the sequencer finishes a decision.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == fsk4_pkg::ST_OUT))
        else $error("result raised outside the output step");

endmodule

### rtl/core/fsk4_mul.sv
// Shared signed multiplier of the slicer datapath with a registered product.
// Depends on fsk4_pkg for the operand and product types.
`timescale 1ns / 1ps

module fsk4_mul (
    input  logic               aclk,
    input  fsk4_pkg::mul_req_t req,
    output fsk4_pkg::prod_t    product
);

    fsk4_pkg::prod_t product_reg;

    always_ff @(posedge aclk) begin
        product_reg <= fsk4_pkg::prod_t'(req.a) * fsk4_pkg::prod_t'(req.b);
    end

    assign product = product_reg;

endmodule

### sim/fsk4_symbol_timing_slicer_tb.sv
// Self-checking testbench for fsk4_symbol_timing_slicer: a queue-fed sample driver,
// a result monitor and a cycle-free model of the slicer and its timing loop.
// Depends on fsk4_pkg and on the RTL of fsk4_symbol_timing_slicer.
`timescale 1ns / 1ps

module testbench;

    // Fixed-point constants of the timing loop in Q0.16 or Q7.24, and saturation limits.
    localparam longint SMOOTH_GAIN = 6554;      // 0.1, error smoothing
    localparam longint LOOP_GAIN   = 655;       // 0.01, phase integration
    localparam longint PHASE_UNIT  = 16777216;  // 1.0 in Q7.24
    localparam longint V16_MAX     = 32767;
    localparam longint V16_MIN     = -32768;
    localparam longint V32_MAX     = 64'sd2147483647;
    localparam longint V32_MIN     = -64'sd2147483648;

    // Margin after the drain, before a register write.
    localparam int SETTLE_CYCLES = 32;
    localparam int TAIL_LIMIT    = 2000;

    typedef struct packed {
        fsk4_pkg::dibit_t dibit;
        fsk4_pkg::value_t eye;
    } decision_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    fsk4_pkg::value_t     s_sample  = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    fsk4_pkg::dibit_t     m_dibit;
    fsk4_pkg::value_t     m_eye_opening;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    fsk4_pkg::cfg_index_t cfg_index = fsk4_pkg::CFG_SYMBOL_PERIOD;
    logic [fsk4_pkg::CFG_DATA_WIDTH-1:0] cfg_data = '0;

    fsk4_symbol_timing_slicer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_dibit       (m_dibit),
        .m_eye_opening (m_eye_opening),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Samples waiting for the driver, and decisions waiting for the monitor.
    fsk4_pkg::value_t pending_samples[$];
    decision_t        expected_decisions[$];
    int unsigned      samples_queued   = 0;
    int unsigned      samples_accepted = 0;
    int unsigned      error_count      = 0;

    // When set, both the driver and the monitor hold off at random. It is only
    // changed on a falling edge, so the clocked blocks never race with it.
    bit stall_enable = 1'b1;

    // Shadow copy of the slicer state and of its two registers.
    fsk4_pkg::count_t cur_period;
    fsk4_pkg::alpha_t cur_alpha;
    fsk4_pkg::count_t sample_cnt;
    fsk4_pkg::value_t level_avg[4];
    fsk4_pkg::value_t level_thr[3];
    fsk4_pkg::value_t sym_hist[3];
    int               hist_len;
    fsk4_pkg::acc_t   err_smooth;
    fsk4_pkg::acc_t   loop_phase;

    task automatic flag_error(input string msg);
        $display("%0t ns: ERROR %s", $time, msg);
        error_count++;
    endtask

    function automatic longint clamp_range(longint x, longint lo, longint hi);
        if (x > hi) begin
            return hi;
        end else if (x < lo) begin
            return lo;
        end
        return x;
    endfunction

    // Multiply by a Q0.16 weight and round to nearest, ties upward.
    function automatic longint scale_q16(longint x, longint k);
        return (x * k + 32768) >>> 16;
    endfunction

    function automatic void reset_tracker();
        cur_period   = 7'd10;
        cur_alpha    = 16'd655;
        sample_cnt   = '0;
        level_avg[0] = -16'sd4096;
        level_avg[1] = -16'sd1352;
        level_avg[2] = 16'sd1352;
        level_avg[3] = 16'sd4096;
        level_thr[0] = -16'sd2048;
        level_thr[1] = 16'sd0;
        level_thr[2] = 16'sd2048;
        for (int i = 0; i < 3; i++) begin
            sym_hist[i] = '0;
        end
        hist_len   = 0;
        err_smooth = '0;
        loop_phase = '0;
    endfunction

    // Advances the shadow state by one accepted sample. When the sample lands on
    // a symbol decision, the decided dibit and the eye opening are queued.
    function automatic void slice_and_track(fsk4_pkg::value_t smp);
        longint    v;
        longint    err;
        longint    acc;
        int        d;
        decision_t dec;
        v = longint'(smp);
        sample_cnt = sample_cnt + 1'b1;
        if (sample_cnt < cur_period) begin
            return;
        end
        sample_cnt = '0;

        if (v < longint'(level_thr[0])) begin
            d = 0;
        end else if (v < longint'(level_thr[1])) begin
            d = 1;
        end else if (v < longint'(level_thr[2])) begin
            d = 2;
        end else begin
            d = 3;
        end

        // Only the average of the decided level moves; thresholds follow it.
        acc = longint'(level_avg[d]) +
              scale_q16(v - longint'(level_avg[d]), longint'(cur_alpha));
        level_avg[d] = fsk4_pkg::value_t'(clamp_range(acc, V16_MIN, V16_MAX));
        for (int i = 0; i < 3; i++) begin
            level_thr[i] = fsk4_pkg::value_t'(
                (longint'(level_avg[i]) + longint'(level_avg[i + 1])) >>> 1);
        end
        dec.dibit = fsk4_pkg::dibit_t'(d);
        dec.eye   = fsk4_pkg::value_t'((longint'(level_avg[3]) - longint'(level_avg[0])) / 3);

        sym_hist[0] = sym_hist[1];
        sym_hist[1] = sym_hist[2];
        sym_hist[2] = smp;
        if (hist_len < 3) begin
            hist_len++;
        end

        // The timing loop only runs once three symbol values are held.
        if (hist_len >= 3) begin
            err = (longint'(sym_hist[2]) - longint'(sym_hist[0])) * longint'(sym_hist[1]);
            acc = longint'(err_smooth) +
                  scale_q16(err - longint'(err_smooth), SMOOTH_GAIN);
            err_smooth = fsk4_pkg::acc_t'(clamp_range(acc, V32_MIN, V32_MAX));
            acc = longint'(loop_phase) + scale_q16(longint'(err_smooth), LOOP_GAIN);
            acc = clamp_range(acc, V32_MIN, V32_MAX);
            if (acc > PHASE_UNIT) begin
                // Phase overflow: the next decision comes one sample early.
                acc = acc - PHASE_UNIT;
                sample_cnt = sample_cnt + 1'b1;
            end else if (acc < -PHASE_UNIT) begin
                // Phase underflow: the counter is already at zero and stays there.
                acc = acc + PHASE_UNIT;
                if (sample_cnt != '0) begin
                    sample_cnt = sample_cnt - 1'b1;
                end
            end
            loop_phase = fsk4_pkg::acc_t'(acc);
        end
        expected_decisions.insert(expected_decisions.size(), dec);
    endfunction

    // Sample driver. Valid stays up with a steady payload until the transaction
    // completes; a new sample is offered only when the channel is free.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                slice_and_track(s_sample);
                samples_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pending_samples.size() != 0 &&
                    !(stall_enable && $urandom_range(99) < 29)) begin
                    s_valid  <= 1'b1;
                    s_sample <= pending_samples.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. Each completed transaction is checked against the oldest
    // outstanding decision; ready toggles at random while stalling is enabled.
    always @(posedge aclk) begin : result_monitor
        decision_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_decisions.size() == 0) begin
                    flag_error($sformatf("result with no decision pending: dibit %0d eye %0d",
                                         m_dibit, m_eye_opening));
                end else begin
                    want = expected_decisions.pop_front();
                    if (m_dibit !== want.dibit) begin
                        flag_error($sformatf("dibit is %0d, expected %0d",
                                             m_dibit, want.dibit));
                    end
                    if (m_eye_opening !== want.eye) begin
                        flag_error($sformatf("eye opening is %0d, expected %0d",
                                             m_eye_opening, want.eye));
                    end
                end
            end
            m_ready <= !(stall_enable && $urandom_range(99) < 29);
        end
    end

    task automatic queue_sample(input fsk4_pkg::value_t x);
        pending_samples.insert(pending_samples.size(), x);
        samples_queued++;
    endtask

    // Blocks until every queued sample has been taken and every decision seen.
    task automatic wait_for_drain();
        do begin
            @(negedge aclk);
        end while (samples_accepted != samples_queued || expected_decisions.size() != 0);
    endtask

    // Writes both registers back to back while the slicer is idle. Valid stays
    // high between the two transactions and drops after the second one.
    task automatic program_slicer(input logic [fsk4_pkg::CFG_DATA_WIDTH-1:0] period_word,
                                  input logic [fsk4_pkg::CFG_DATA_WIDTH-1:0] alpha_word);
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= fsk4_pkg::CFG_SYMBOL_PERIOD;
        cfg_data  <= period_word;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cur_period = fsk4_pkg::count_t'(period_word);
        cfg_index <= fsk4_pkg::CFG_SLICER_ALPHA;
        cfg_data  <= alpha_word;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cur_alpha = fsk4_pkg::alpha_t'(alpha_word);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // A burst of symbols near the four nominal levels, each held for a full
    // symbol period, with the odd symbol replaced by a full-scale random value.
    task automatic queue_symbols(input int count, input int per);
        int nominal[4];
        int lvl;
        nominal = '{-4096, -1352, 1352, 4096};
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(9) == 0) begin
                lvl = int'($signed(16'($urandom)));
            end else begin
                lvl = nominal[$urandom_range(3)] * int'($urandom_range(75, 125)) / 100
                      + int'($urandom_range(800)) - 400;
            end
            repeat (per) queue_sample(fsk4_pkg::value_t'(clamp_range(lvl, V16_MIN, V16_MAX)));
        end
    endtask

    // The timing error sums to the change of h[n]*h[n+1], so switching between a
    // held full-scale level and a full-scale alternation swings the phase by about
    // one whole unit. That drives the accumulator past +1.0 or -1.0.
    task automatic queue_timing_swing(input int per);
        int hold_amp;
        int alt_amp;
        int lvl;
        bit hold_first;
        hold_amp   = int'($urandom_range(28000, 32767));
        alt_amp    = int'($urandom_range(28000, 32767));
        hold_first = $urandom_range(1);
        if ($urandom_range(1) == 1) begin
            hold_amp = -hold_amp;
        end
        for (int half = 0; half < 2; half++) begin
            for (int k = 0; k < 40; k++) begin
                if ((half == 0) == hold_first) begin
                    lvl = hold_amp;
                end else begin
                    lvl = (k % 2 == 1) ? alt_amp : -alt_amp;
                end
                repeat (per) queue_sample(fsk4_pkg::value_t'(lvl));
            end
        end
    endtask

    // Mostly symbol-aligned traffic, with timing swings where the period is short
    // and bursts of raw noise that knock the alignment around. Long periods use
    // single-symbol bursts to keep the sample count moderate.
    task automatic queue_traffic(input int count, input int period);
        int per;
        int start;
        int pick;
        per   = (period < 1) ? 1 : period;
        start = int'(samples_queued);
        while (int'(samples_queued) - start < count) begin
            pick = int'($urandom_range(99));
            if (pick < 20 && per <= 4) begin
                queue_timing_swing(per);
            end else if (pick < 85) begin
                queue_symbols((per > 16) ? 1 : 4, per);
            end else begin
                repeat ($urandom_range(1, 2 * per)) queue_sample(fsk4_pkg::value_t'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        int tail;
        fsk4_pkg::value_t edge_values[$];
        reset_tracker();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset configuration: ten samples, the tenth is the first decision.
        edge_values = '{16'sd0, 16'sd32767, -16'sd32768, 16'sd1, -16'sd1,
                        16'sh5555, -16'sh5556, 16'sd100, -16'sd100, 16'sd4096};
        foreach (edge_values[i]) queue_sample(edge_values[i]);

        // One decision per sample and full-weight adaptation, so every sample
        // below is sliced on its own: the full-scale ends and both sides of the
        // nominal thresholds.
        program_slicer(16'd1, 16'hFFFF);
        edge_values = '{16'sd32767, -16'sd32768, -16'sd2049, -16'sd2048, -16'sd1,
                        16'sd0, 16'sd2047, 16'sd2048, 16'sd4096, -16'sd4096,
                        16'sd1352, -16'sd1352, 16'sd32767, -16'sd32768};
        foreach (edge_values[i]) queue_sample(edge_values[i]);

        // A period of zero makes every sample a decision; the upper data bits
        // beyond the counter width must be dropped.
        program_slicer(16'($urandom_range(511) << 7), 16'($urandom));
        queue_traffic(60, 0);

        // Frozen averages while the timing loop is pushed hard.
        program_slicer(16'd1, 16'd0);
        queue_traffic(150, 1);

        // A long stretch with no idling on either side.
        program_slicer(16'd2, 16'($urandom));
        stall_enable = 1'b0;
        queue_traffic(100, 2);

        program_slicer(16'd5, 16'd655);
        stall_enable = 1'b1;
        queue_traffic(100, 5);

        program_slicer(16'd64, 16'hFFFF);
        queue_traffic(100, 64);

        // The widest period the counter allows, beyond the nominal range.
        program_slicer(16'($urandom_range(511) << 7) | 16'd127, 16'($urandom));
        queue_traffic(60, 127);

        program_slicer(16'd3, 16'($urandom));
        queue_traffic(60, 3);

        // All samples must be taken; then the remaining decisions get a bounded wait.
        do begin
            @(negedge aclk);
        end while (samples_accepted != samples_queued);
        tail = 0;
        while (expected_decisions.size() != 0 && tail < TAIL_LIMIT) begin
            @(negedge aclk);
            tail++;
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (expected_decisions.size() != 0) begin
            flag_error($sformatf("%0d decisions never came out", expected_decisions.size()));
        end

        if (error_count == 0) begin
            $display("fsk4_symbol_timing_slicer verification clean");
        end else begin
            $display("fsk4_symbol_timing_slicer verification failed");
        end
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin
        #5000000;
        $display("fsk4_symbol_timing_slicer verification failed");
        $finish;
    end

endmodule

### files.f
rtl/core/fsk4_pkg.sv
rtl/core/fsk4_mul.sv
rtl/core/fsk4_symbol_timing_slicer.sv
sim/fsk4_symbol_timing_slicer_tb.sv
